// ----- sv/fmenc_pkg.sv -----
package fmenc_pkg;

    localparam logic [2:0] ACT_BYTE      = 3'd0;
    localparam logic [2:0] ACT_BYTE_CRC  = 3'd1;
    localparam logic [2:0] ACT_BYTE_CLK  = 3'd2;
    localparam logic [2:0] ACT_EMIT_CRC  = 3'd3;
    localparam logic [2:0] ACT_LOAD_SEED = 3'd4;

    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [15:0] CRC_RESET    = 16'hffff;
    localparam logic [15:0] BAD_CRC_MASK = 16'h5555;

    localparam logic [5:0] MFM_CELLS = 6'd16;
    localparam logic [5:0] FM_CELLS  = 6'd32;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  data_byte;
        logic [7:0]  clock_pattern;
        logic        corrupt_crc;
        logic [15:0] crc_seed;
    } in_item_t;

    typedef struct packed {
        logic [31:0] cells;
        logic [5:0]  cell_count;
        logic        last_of_run;
    } out_item_t;

    typedef enum logic [1:0] {
        JOB_BYTE,
        JOB_BYTE_CLK,
        JOB_CRC
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [15:0] value;
        logic [7:0]  clock_pattern;
    } job_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [7:0] mfm_clock(input logic prev, input logic [7:0] data);
        logic [7:0] clk_bits;
        logic       p;
        p = prev;
        clk_bits = '0;
        for (int i = 7; i >= 0; i--) begin
            clk_bits[i] = ~p & ~data[i];
            p = data[i];
        end
        return clk_bits;
    endfunction

    function automatic logic [15:0] interleave(input logic [7:0] clk_bits,
                                               input logic [7:0] data);
        logic [15:0] raw;
        raw = '0;
        for (int i = 0; i < 8; i++) begin
            raw[2*i+1] = clk_bits[i];
            raw[2*i]   = data[i];
        end
        return raw;
    endfunction

    function automatic logic [31:0] fm_widen(input logic [15:0] raw);
        logic [31:0] w;
        w = '0;
        for (int i = 0; i < 16; i++) begin
            w[2*i+1] = raw[i];
        end
        return w;
    endfunction

endpackage

// ----- sv/fmenc_front.sv -----
module fmenc_front
    import fmenc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_data,
    output logic     push,
    output job_t     push_job,
    input  logic     q_full
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic        accept;

    assign in_ready = ~q_full;
    assign accept   = in_valid & ~q_full;

    always_comb
    begin
        crc_next               = crc_reg;
        push                   = 1'b0;
        push_job.kind          = JOB_BYTE;
        push_job.value         = {8'h00, in_data.data_byte};
        push_job.clock_pattern = in_data.clock_pattern;
        if (accept)
        begin
            unique case (in_data.action)
                ACT_BYTE:
                begin
                    push = 1'b1;
                end
                ACT_BYTE_CRC:
                begin
                    push     = 1'b1;
                    crc_next = crc_byte(crc_reg, in_data.data_byte);
                end
                ACT_BYTE_CLK:
                begin
                    push          = 1'b1;
                    push_job.kind = JOB_BYTE_CLK;
                end
                ACT_EMIT_CRC:
                begin
                    push           = 1'b1;
                    push_job.kind  = JOB_CRC;
                    push_job.value = crc_reg ^ (in_data.corrupt_crc ? BAD_CRC_MASK : 16'h0000);
                end
                ACT_LOAD_SEED:
                begin
                    crc_next = in_data.crc_seed;
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= CRC_RESET;
        end
        else
        begin
            crc_reg <= crc_next;
        end
    end

endmodule

// ----- sv/fmenc_queue.sv -----
module fmenc_queue
    import fmenc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head_job
);

    job_t                 mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full       = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem_reg[rd_ptr_reg];
    assign do_push    = push & ~full;
    assign do_pop     = pop & head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count over depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !head_valid))
        else $error("pop from empty queue");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("pointers differ on empty queue");

endmodule

// ----- sv/fmenc_back.sv -----
module fmenc_back
    import fmenc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fm_mode,
    input  logic      head_valid,
    input  job_t      head_job,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic        prev_bit_reg;
    logic        half_reg;
    logic        half_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    out_item_t   out_reg;
    out_item_t   result;
    logic [7:0]  byte_sel;
    logic [7:0]  clk_bits;
    logic [15:0] raw;
    logic        is_last;
    logic        load;

    assign load = head_valid & (~out_valid_reg | out_ready);

    always_comb
    begin
        if (head_job.kind == JOB_CRC)
        begin
            byte_sel = half_reg ? head_job.value[7:0] : head_job.value[15:8];
        end
        else
        begin
            byte_sel = head_job.value[7:0];
        end
        if (head_job.kind == JOB_BYTE_CLK)
        begin
            clk_bits = head_job.clock_pattern;
        end
        else if (fm_mode)
        begin
            clk_bits = 8'hff;
        end
        else
        begin
            clk_bits = mfm_clock(prev_bit_reg, byte_sel);
        end
        raw     = interleave(clk_bits, byte_sel);
        is_last = (head_job.kind != JOB_CRC) | half_reg;
        result.cells       = fm_mode ? fm_widen(raw) : {16'h0000, raw};
        result.cell_count  = fm_mode ? FM_CELLS : MFM_CELLS;
        result.last_of_run = is_last;
        pop       = load & is_last;
        half_next = half_reg;
        if (load)
        begin
            half_next = ~is_last;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_bit_reg  <= 1'b0;
            half_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            half_reg      <= half_next;
            if (load)
            begin
                prev_bit_reg <= byte_sel[0];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_half_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.last_of_run) |-> half_reg)
        else $error("first crc byte out without second pending");

    a_half_head: assert property (@(posedge clk) disable iff (!rst_n)
        half_reg |-> (head_valid && head_job.kind == JOB_CRC))
        else $error("crc second half without crc job at head");

    a_prev_bit: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (prev_bit_reg == (fm_mode ? out_reg.cells[1] : out_reg.cells[0])))
        else $error("clock history does not follow last data cell");

endmodule

// ----- sv/fm_mfm_byte_encoder_crc_top.sv -----
// Floppy byte encoder: each transfer on the input channel carries an action that turns a
// byte into raw flux cells, MSB first, with a running CRC-16-CCITT (reset 0xFFFF).
// Each sent byte yields one result of 16 cells (MFM) or 32 cells (FM); emitting the CRC
// yields two results, high byte first, and loading a seed yields none. One item is
// accepted per cycle unless the job queue is full; a CRC emit occupies the output side
// for two results, absorbed by a four-entry job queue between the front (action decode,
// CRC register) and the back (cell expansion, clock history, output register). The user
// writes fm_mode through cfg_valid/cfg_data only while the block is idle; the block does not enforce it.
module fm_mfm_byte_encoder_crc_top
    import fmenc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_data
);

    logic fm_mode_reg;
    logic push;
    job_t push_job;
    logic q_full;
    logic pop;
    logic head_valid;
    job_t head_job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fm_mode_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            fm_mode_reg <= cfg_data;
        end
    end

    fmenc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .push     (push),
        .push_job (push_job),
        .q_full   (q_full)
    );

    fmenc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    fmenc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fm_mode    (fm_mode_reg),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

// ----- test/fm_mfm_byte_encoder_crc_top_tb.sv -----
`timescale 1ns / 100ps

module fm_mfm_byte_encoder_crc_top_tb;
    import fmenc_pkg::*;

    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;
    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 195;
    localparam int MAX_REPORTS = 10;

    class cell_scoreboard;
        logic        fm_mode;
        logic        last_data_bit;
        logic [15:0] crc_reg;
        out_item_t   expected_cells[$];
        int          mismatches;

        function new();
            fm_mode = 1'b0;
            last_data_bit = 1'b0;
            crc_reg = CRC_RESET;
            mismatches = 0;
        endfunction

        function logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] data);
            logic [15:0] c;
            logic        fb;
            c = crc;
            for (int i = 7; i >= 0; i--)
            begin
                fb = c[15] ^ data[i];
                c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
            end
            return c;
        endfunction

        function void push_cells(input logic [7:0] clock_bits, input logic [7:0] data,
                                 input logic last);
            out_item_t   res;
            logic [15:0] raw;
            logic [31:0] wide;
            raw = '0;
            wide = '0;
            for (int i = 7; i >= 0; i--)
            begin
                raw = {raw[13:0], clock_bits[i], data[i]};
            end
            if (fm_mode)
            begin
                for (int i = 15; i >= 0; i--)
                begin
                    wide = {wide[29:0], raw[i], 1'b0};
                end
                res.cell_count = FM_CELLS;
            end
            else
            begin
                wide = {16'h0000, raw};
                res.cell_count = MFM_CELLS;
            end
            res.cells = wide;
            res.last_of_run = last;
            expected_cells.push_back(res);
            last_data_bit = data[0];
        endfunction

        function void push_data(input logic [7:0] data, input logic last);
            logic [7:0] clock_bits;
            logic       p;
            p = last_data_bit;
            clock_bits = 8'hff;
            if (!fm_mode)
            begin
                for (int i = 7; i >= 0; i--)
                begin
                    clock_bits[i] = ~(p | data[i]);
                    p = data[i];
                end
            end
            push_cells(clock_bits, data, last);
        endfunction

        function void note_input(input in_item_t item);
            logic [15:0] v;
            case (item.action)
                ACT_BYTE:
                begin
                    push_data(item.data_byte, 1'b1);
                end
                ACT_BYTE_CRC:
                begin
                    push_data(item.data_byte, 1'b1);
                    crc_reg = crc_update(crc_reg, item.data_byte);
                end
                ACT_BYTE_CLK:
                begin
                    push_cells(item.clock_pattern, item.data_byte, 1'b1);
                end
                ACT_EMIT_CRC:
                begin
                    v = crc_reg ^ (item.corrupt_crc ? BAD_CRC_MASK : 16'h0000);
                    push_data(v[15:8], 1'b0);
                    push_data(v[7:0], 1'b1);
                end
                ACT_LOAD_SEED:
                begin
                    crc_reg = item.crc_seed;
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_result(input out_item_t got);
            out_item_t want;
            if (expected_cells.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("%0t: unexpected result cells=%h count=%0d last=%b",
                             $time, got.cells, got.cell_count, got.last_of_run);
                end
                return;
            end
            want = expected_cells.pop_front();
            if (got.cells !== want.cells || got.cell_count !== want.cell_count ||
                got.last_of_run !== want.last_of_run)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("%0t: mismatch exp cells=%h count=%0d last=%b", $time,
                             want.cells, want.cell_count, want.last_of_run);
                    $display("%0t:          got cells=%h count=%0d last=%b", $time,
                             got.cells, got.cell_count, got.last_of_run);
                end
            end
        endfunction

        function int pending();
            return expected_cells.size();
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic      cfg_data;

    cell_scoreboard sb;
    int             cycle_count;
    bit             steady_send;
    bit             hold_off_req;
    int             sent_count;

    fm_mfm_byte_encoder_crc_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    function automatic in_item_t make_item(input logic [2:0] action, input logic [7:0] data,
                                           input logic [7:0] clock_bits, input logic corrupt,
                                           input logic [15:0] seed);
        in_item_t item;
        item.action = action;
        item.data_byte = data;
        item.clock_pattern = clock_bits;
        item.corrupt_crc = corrupt;
        item.crc_seed = seed;
        return item;
    endfunction

    function automatic in_item_t random_item(input logic [2:0] action);
        return make_item(action, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
    endfunction

    task automatic send_item(input in_item_t item);
        int gap;
        gap = steady_send ? 0 : idle_len();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data <= item;
        do @(posedge clk); while (!in_ready);
        sb.note_input(item);
        if (item.action < ACT_SPARE_LO)
        begin
            sent_count++;
        end
    endtask

    task automatic drain_outputs();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic mode);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= mode;
        do @(posedge clk); while (!cfg_ready);
        sb.fm_mode = mode;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_record();
        int n;
        case ($urandom_range(0, 2))
            0: send_item(make_item(ACT_LOAD_SEED, 8'($urandom_range(0, 255)),
                                   8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                   16'hcdb4));
            1: send_item(random_item(ACT_LOAD_SEED));
            default: ;
        endcase
        n = $urandom_range(0, 3);
        repeat (n)
        begin
            if ($urandom_range(0, 1))
            begin
                send_item(make_item(ACT_BYTE_CLK, 8'ha1, 8'h0a, 1'($urandom_range(0, 1)),
                                    16'($urandom_range(0, 65535))));
            end
            else
            begin
                send_item(random_item(ACT_BYTE_CLK));
            end
        end
        n = $urandom_range(1, 10);
        repeat (n)
        begin
            send_item(random_item($urandom_range(0, 5) == 0 ? ACT_BYTE : ACT_BYTE_CRC));
        end
        send_item(make_item(ACT_EMIT_CRC, 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0,
                            16'($urandom_range(0, 65535))));
    endtask

    task automatic send_noise();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
        begin
            send_item(random_item(ACT_BYTE));
        end
        else if (r < 40)
        begin
            send_item(random_item(ACT_BYTE_CRC));
        end
        else if (r < 60)
        begin
            send_item(random_item(ACT_BYTE_CLK));
        end
        else if (r < 75)
        begin
            send_item(random_item(ACT_EMIT_CRC));
        end
        else if (r < 90)
        begin
            send_item(random_item(ACT_LOAD_SEED));
        end
        else
        begin
            send_item(random_item(3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI))));
        end
    endtask

    task automatic run_directed();
        send_item(make_item(ACT_BYTE, 8'h00, 8'h00, 1'b0, 16'h0000));
        send_item(make_item(ACT_BYTE, 8'hff, 8'hff, 1'b1, 16'hffff));
        send_item(make_item(ACT_BYTE, 8'h80, 8'h00, 1'b0, 16'h0000));
        send_item(make_item(ACT_BYTE, 8'h01, 8'h00, 1'b0, 16'h0000));
        send_item(make_item(ACT_BYTE_CLK, 8'ha1, 8'h0a, 1'b0, 16'h0000));
        send_item(make_item(ACT_BYTE_CLK, 8'hc2, 8'h14, 1'b0, 16'h0000));
        send_item(make_item(ACT_BYTE_CLK, 8'h00, 8'hff, 1'b0, 16'h0000));
        send_item(make_item(ACT_BYTE_CLK, 8'hff, 8'h00, 1'b1, 16'hffff));
        send_item(make_item(ACT_LOAD_SEED, 8'h00, 8'h00, 1'b0, 16'hcdb4));
        send_item(make_item(ACT_BYTE_CRC, 8'hfe, 8'h00, 1'b0, 16'h0000));
        send_item(make_item(ACT_BYTE_CRC, 8'h00, 8'h00, 1'b0, 16'h0000));
        send_item(make_item(ACT_BYTE_CRC, 8'hff, 8'hff, 1'b1, 16'hffff));
        send_item(make_item(ACT_EMIT_CRC, 8'h00, 8'h00, 1'b0, 16'h0000));
        send_item(make_item(ACT_EMIT_CRC, 8'hff, 8'hff, 1'b1, 16'hffff));
        send_item(make_item(ACT_LOAD_SEED, 8'hff, 8'hff, 1'b1, 16'h0000));
        send_item(make_item(ACT_EMIT_CRC, 8'h00, 8'h00, 1'b0, 16'h0000));
        send_item(make_item(ACT_LOAD_SEED, 8'h00, 8'h00, 1'b0, 16'hffff));
        send_item(make_item(ACT_EMIT_CRC, 8'h00, 8'h00, 1'b1, 16'h0000));
        send_item(make_item(ACT_SPARE_LO, 8'hff, 8'hff, 1'b1, 16'hffff));
        send_item(make_item(ACT_SPARE_HI, 8'hff, 8'hff, 1'b1, 16'h0000));
        send_item(make_item(ACT_BYTE, 8'h55, 8'h00, 1'b0, 16'h0000));
        send_item(make_item(ACT_BYTE_CRC, 8'haa, 8'h00, 1'b0, 16'h0000));
    endtask

    // result side: random stalls, long clear runs, one long hold-off on request
    initial
    begin
        int run_len;
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
                hold_off_req = 1'b0;
            end
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                    : $urandom_range(1, 20);
            @(negedge clk);
            out_ready <= 1'b1;
            for (int k = 1; k < run_len && !hold_off_req; k++)
            begin
                @(negedge clk);
            end
            stall = idle_len();
            if (stall > 0)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_result(out_data);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("fm_mfm_byte_encoder_crc_top_tb: FAIL");
        $finish;
    end

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        steady_send = 1'b0;
        hold_off_req = 1'b0;
        sent_count = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_mode(1'b0);
        run_directed();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_outputs();
            write_mode(phase % 2 == 0);
            steady_send = (phase == 3) || (phase == 6);
            if (phase == 3)
            begin
                hold_off_req = 1'b1;
            end
            sent_count = 0;
            while (sent_count < ITEMS_PER_PHASE)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    send_record();
                end
                else
                begin
                    send_noise();
                end
            end
            steady_send = 1'b0;
        end

        drain_outputs();
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("fm_mfm_byte_encoder_crc_top_tb: PASS");
        end
        else
        begin
            $display("fm_mfm_byte_encoder_crc_top_tb: FAIL");
        end
        $finish;
    end

endmodule
